// File: hdl/ccks_pkg.sv
// ----------------------------------------------------------------------------
// ccks_pkg
// Shared types, constants and round functions of the chacha20 keystream xor.
// ----------------------------------------------------------------------------
package ccks_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUND_STEPS   = DOUBLE_ROUNDS * 4;
  localparam int STEP_W        = $clog2(ROUND_STEPS);
  localparam int BLOCK_BYTES   = 64;
  localparam int POS_W         = 7;
  localparam int ADDR_W        = 6;

  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  localparam int ROT_A = 16;
  localparam int ROT_B = 12;
  localparam int ROT_C = 8;
  localparam int ROT_D = 7;

  localparam logic [2:0] REG_KEY_01   = 3'd0;
  localparam logic [2:0] REG_KEY_23   = 3'd1;
  localparam logic [2:0] REG_KEY_45   = 3'd2;
  localparam logic [2:0] REG_KEY_67   = 3'd3;
  localparam logic [2:0] REG_NONCE_01 = 3'd4;
  localparam logic [2:0] REG_NONCE_2  = 3'd5;
  localparam logic [2:0] REG_INIT_CTR = 3'd6;

  typedef logic [15:0][31:0] words_t;

  typedef struct packed {
    logic [63:0] key_01;
    logic [63:0] key_23;
    logic [63:0] key_45;
    logic [63:0] key_67;
    logic [63:0] nonce_01;
    logic [31:0] nonce_2;
    logic [31:0] init_ctr;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic diag;
    logic second;
    logic feed;
    logic emit;
    logic use_hold;
  } ctrl_t;

  typedef struct packed {
    logic need_block;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // one half of a quarter-round: two dependent adds
  function automatic qr_t qr_half(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c, input logic [31:0] d,
                                  input logic second);
    qr_t r;
    logic [31:0] na, nb, nc, nd;
    na = a + b;
    nd = second ? rotl(d ^ na, ROT_C) : rotl(d ^ na, ROT_A);
    nc = c + nd;
    nb = second ? rotl(b ^ nc, ROT_D) : rotl(b ^ nc, ROT_B);
    r.a = na;
    r.b = nb;
    r.c = nc;
    r.d = nd;
    return r;
  endfunction

  function automatic words_t build_init(input cfg_t cfg, input logic [31:0] ctr);
    words_t w;
    w[0]  = SIGMA_0;
    w[1]  = SIGMA_1;
    w[2]  = SIGMA_2;
    w[3]  = SIGMA_3;
    w[4]  = cfg.key_01[31:0];
    w[5]  = cfg.key_01[63:32];
    w[6]  = cfg.key_23[31:0];
    w[7]  = cfg.key_23[63:32];
    w[8]  = cfg.key_45[31:0];
    w[9]  = cfg.key_45[63:32];
    w[10] = cfg.key_67[31:0];
    w[11] = cfg.key_67[63:32];
    w[12] = ctr;
    w[13] = cfg.nonce_01[31:0];
    w[14] = cfg.nonce_01[63:32];
    w[15] = cfg.nonce_2;
    return w;
  endfunction

endpackage

// File: hdl/ccks_cfg.sv
// ----------------------------------------------------------------------------
// ccks_cfg
// APB register file holding key, nonce and initial counter.
// ----------------------------------------------------------------------------
module ccks_cfg import ccks_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_KEY_01:   cfg_q.key_01   <= pwdata;
        REG_KEY_23:   cfg_q.key_23   <= pwdata;
        REG_KEY_45:   cfg_q.key_45   <= pwdata;
        REG_KEY_67:   cfg_q.key_67   <= pwdata;
        REG_NONCE_01: cfg_q.nonce_01 <= pwdata;
        REG_NONCE_2:  cfg_q.nonce_2  <= pwdata[31:0];
        REG_INIT_CTR: cfg_q.init_ctr <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY_01:   prdata = cfg_q.key_01;
      REG_KEY_23:   prdata = cfg_q.key_23;
      REG_KEY_45:   prdata = cfg_q.key_45;
      REG_KEY_67:   prdata = cfg_q.key_67;
      REG_NONCE_01: prdata = cfg_q.nonce_01;
      REG_NONCE_2:  prdata = {32'd0, cfg_q.nonce_2};
      REG_INIT_CTR: prdata = {32'd0, cfg_q.init_ctr};
      default:      prdata = '0;
    endcase
  end

endmodule

// File: hdl/ccks_ctrl.sv
// ----------------------------------------------------------------------------
// ccks_ctrl
// Sequencer: accepts bytes, runs the round steps of a block refill, emits.
// ----------------------------------------------------------------------------
module ccks_ctrl import ccks_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  status_t status_i,
  output ctrl_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FEED  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              accept;

  assign s_axis_tready = (state_q == ST_IDLE) & ~status_i.out_busy;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.need_block) begin
            cmd_o.load = 1'b1;
            step_d     = '0;
            state_d    = ST_ROUND;
          end else begin
            cmd_o.emit = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.step   = 1'b1;
        cmd_o.second = step_q[0];
        cmd_o.diag   = step_q[1];
        step_d       = step_q + 1'b1;
        if (step_q == STEP_W'(ROUND_STEPS - 1)) begin
          state_d = ST_FEED;
        end
      end
      ST_FEED: begin
        cmd_o.feed = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit     = 1'b1;
          cmd_o.use_hold = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: hdl/ccks_dp.sv
// ----------------------------------------------------------------------------
// ccks_dp
// Datapath: working words, keystream block, counter, byte position, output.
// ----------------------------------------------------------------------------
module ccks_dp import ccks_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  ctrl_t      cmd_i,
  output status_t    status_o,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tuser,
  input  logic       s_axis_tlast,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready
);

  words_t           work_q, work_d;
  words_t           ks_q;
  words_t           init_w;
  logic [31:0]      ctr_q, ctr_load;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       hold_data_q;
  logic             hold_last_q;
  logic             m_valid_q;
  logic [7:0]       m_data_q;
  logic             m_last_q;
  logic [31:0]      ks_word;
  logic [7:0]       ks_byte;
  logic [7:0]       src_data;
  logic             src_last;

  assign status_o.need_block = s_axis_tuser | pos_q[POS_W-1];
  assign status_o.out_busy   = m_valid_q & ~m_axis_tready;

  assign ctr_load = s_axis_tuser ? cfg_i.init_ctr : ctr_q;
  assign init_w   = build_init(cfg_i, ctr_q);

  // four quarter-rounds side by side, half a quarter-round per step
  always_comb begin
    logic [1:0] lane, sh;
    logic [3:0] ia, ib, ic, id;
    qr_t        r;
    work_d = work_q;
    sh     = {1'b0, cmd_i.diag};
    for (int i = 0; i < 4; i++) begin
      lane = 2'(i);
      ia   = {2'b00, lane};
      ib   = {2'b01, 2'(lane + sh)};
      ic   = {2'b10, 2'(lane + (sh << 1))};
      id   = {2'b11, 2'(lane + sh + (sh << 1))};
      r    = qr_half(work_q[ia], work_q[ib], work_q[ic], work_q[id], cmd_i.second);
      work_d[ia] = r.a;
      work_d[ib] = r.b;
      work_d[ic] = r.c;
      work_d[id] = r.d;
    end
  end

  assign ks_word  = ks_q[pos_q[5:2]];
  assign ks_byte  = 8'(ks_word >> {pos_q[1:0], 3'b000});
  assign src_data = cmd_i.use_hold ? hold_data_q : s_axis_tdata;
  assign src_last = cmd_i.use_hold ? hold_last_q : s_axis_tlast;

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.feed) begin
      pos_d = '0;
    end else if (cmd_i.emit) begin
      pos_d = src_last ? POS_W'(BLOCK_BYTES) : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q      <= build_init(cfg_i, ctr_load);
      hold_data_q <= s_axis_tdata;
      hold_last_q <= s_axis_tlast;
    end else if (cmd_i.step) begin
      work_q <= work_d;
    end
    if (cmd_i.feed) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= work_q[i] + init_w[i];
      end
    end
    if (cmd_i.emit) begin
      m_data_q <= src_data ^ ks_byte;
      m_last_q <= src_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q     <= '0;
      pos_q     <= POS_W'(BLOCK_BYTES);
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ctr_q <= ctr_load;
      end else if (cmd_i.feed) begin
        ctr_q <= ctr_q + 1'b1;
      end
      pos_q <= pos_d;
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tvalid = m_valid_q;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(BLOCK_BYTES))
    else $error("byte position beyond block");

  a_feed_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.feed |=> pos_q == '0)
    else $error("position not rewound after refill");

  a_last_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && src_last) |=> pos_q == POS_W'(BLOCK_BYTES))
    else $error("keystream kept after end of call");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !status_o.out_busy)
    else $error("output overwritten while stalled");
`endif

endmodule

// File: hdl/chacha20_keystream_xor.sv
// ----------------------------------------------------------------------------
// chacha20_keystream_xor
// ChaCha20 stream cipher, one data byte XORed with one keystream byte.
// ----------------------------------------------------------------------------
// usage:
//   load key, nonce and initial counter over apb while no byte is in flight
//   input stream: tdata carries the byte, tuser starts a message (counter
//   reload, buffered keystream dropped), tlast ends a call (rest of the
//   block dropped after this byte)
//   output stream: tdata is byte xor keystream, tlast copies the input tlast
//   latency: a byte that finds keystream in the buffer shows up in the cycle
//   after its transfer; a byte that needs a new block passes through the 40
//   half quarter-round steps, the feed-forward and the output register
//   throughput: one byte per cycle in a block unless the output stalls; input
//   waits while the one shared round unit of four quarter-round lanes refills
//   reset: counter zero, buffer empty, registers zero, output idle
//   a stalled receiver holds the output register; one more byte is taken
//   only once the waiting result is transferred or being transferred
// ----------------------------------------------------------------------------
module chacha20_keystream_xor import ccks_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // data_byte
  input  logic              s_axis_tuser,   // start_message
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // out_byte
  output logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  ctrl_t   cmd;
  status_t status;

  ccks_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ccks_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  ccks_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule
